FILE: rtl/vswp_pkg.sv
// Shared widths, register map and paint mode codes for the splat weight painter.
`default_nettype none

package vswp_pkg;

  // Field widths
  localparam int W_BYTE     = 8;
  localparam int W_COLOR    = 32;
  localparam int W_INFL     = 16;
  localparam int W_LAYER    = 2;
  localparam int W_MODE     = 2;
  localparam int NUM_LAYERS = 3;

  // Influence fraction bits, default
  localparam int INFLUENCE_FRAC_BITS_DEF = 12;

  // Configuration port
  localparam int W_CFG_ADDR = 2;
  localparam int W_CFG_DATA = 32;
  localparam logic [W_CFG_ADDR-1:0] ADDR_PAINT_MODE = 2'd0;

  // Paint mode codes
  localparam logic [W_MODE-1:0] MODE_TEX   = 2'd0;
  localparam logic [W_MODE-1:0] MODE_DIFF  = 2'd1;
  localparam logic [W_MODE-1:0] MODE_BOTH  = 2'd2;
  localparam logic [W_MODE-1:0] MODE_RESET = MODE_BOTH;

endpackage

`default_nettype wire

FILE: rtl/vswp_in_if.sv
// Input channel: one vertex item with valid/ready handshake.
`default_nettype none

interface vswp_in_if;
  logic                             valid;
  logic                             ready;
  logic [vswp_pkg::W_BYTE-1:0]      weight_zero;
  logic [vswp_pkg::W_BYTE-1:0]      weight_one;
  logic [vswp_pkg::W_BYTE-1:0]      weight_two;
  logic [vswp_pkg::W_BYTE-1:0]      tex_index_zero;
  logic [vswp_pkg::W_BYTE-1:0]      tex_index_one;
  logic [vswp_pkg::W_BYTE-1:0]      tex_index_two;
  logic [vswp_pkg::W_COLOR-1:0]     cur_color;
  logic [vswp_pkg::W_COLOR-1:0]     target_color;
  logic signed [vswp_pkg::W_INFL-1:0] brush_influence;
  logic [vswp_pkg::W_LAYER-1:0]     paint_layer;
  logic [vswp_pkg::W_BYTE-1:0]      stamp_id;

  modport source (
    output valid, weight_zero, weight_one, weight_two, tex_index_zero, tex_index_one,
           tex_index_two, cur_color, target_color, brush_influence, paint_layer,
           stamp_id,
    input  ready
  );

  modport sink (
    input  valid, weight_zero, weight_one, weight_two, tex_index_zero, tex_index_one,
           tex_index_two, cur_color, target_color, brush_influence, paint_layer,
           stamp_id,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/vswp_out_if.sv
// Result channel: one updated vertex item with valid/ready handshake.
`default_nettype none

interface vswp_out_if;
  logic                         valid;
  logic                         ready;
  logic [vswp_pkg::W_BYTE-1:0]  new_weight_zero;
  logic [vswp_pkg::W_BYTE-1:0]  new_weight_one;
  logic [vswp_pkg::W_BYTE-1:0]  new_weight_two;
  logic [vswp_pkg::W_BYTE-1:0]  new_index_zero;
  logic [vswp_pkg::W_BYTE-1:0]  new_index_one;
  logic [vswp_pkg::W_BYTE-1:0]  new_index_two;
  logic [vswp_pkg::W_COLOR-1:0] new_color;
  logic                         weights_changed;

  modport source (
    output valid, new_weight_zero, new_weight_one, new_weight_two, new_index_zero,
           new_index_one, new_index_two, new_color, weights_changed,
    input  ready
  );

  modport sink (
    input  valid, new_weight_zero, new_weight_one, new_weight_two, new_index_zero,
           new_index_one, new_index_two, new_color, weights_changed,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/vertex_splat_weight_painter.sv
// Vertex splat weight painter: twelve-stage pipeline with APB paint mode register.
//
// One vertex item enters per clock and its result leaves from the output stage; the
// rate is one item per cycle while the output takes results. Each stage holds its item
// until the next stage is free, so bubbles close up and in_ch.ready only falls when
// every stage is full and the output is stalled. Most of the stages go to the two 8-bit
// quotient divisions (the proportional take from the other layers, then the rescale
// to a sum of 255), each spread over four stages at two quotient bits a stage.
// paint_mode must only be written while the pipeline is empty.
`default_nettype none

module vertex_splat_weight_painter #(
  parameter int INFLUENCE_FRAC_BITS = vswp_pkg::INFLUENCE_FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  vswp_in_if.sink                                  in_ch,
  vswp_out_if.source                               out_ch,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [vswp_pkg::W_CFG_ADDR-1:0]     cfg_paddr,
  input  wire logic [vswp_pkg::W_CFG_DATA-1:0]     cfg_pwdata,
  output logic      [vswp_pkg::W_CFG_DATA-1:0]     cfg_prdata,
  output logic                                     cfg_pready
);

  // Stage map
  localparam int ST_IN  = 0;   // clamp, step, colour products
  localparam int ST_PRE = 1;   // painted layer, share numerators, colour blend
  localparam int ST_SD0 = 2;   // share division, four stages
  localparam int ST_MID = 6;   // apply shares, weight sum, rescale numerators
  localparam int ST_RD0 = 7;   // rescale division, four stages
  localparam int ST_OUT = 11;  // pick rescaled or plain weights
  localparam int NS     = 12;
  localparam int DIV_ST = 4;

  localparam logic signed [15:0] ONE_S = 16'(1 << INFLUENCE_FRAC_BITS);

  typedef struct packed {
    logic [2:0][7:0]  w;
    logic [2:0][7:0]  idx;
    logic [7:0]       tid;
    logic [1:0]       layer;
    logic             tex;
    logic [9:0]       step;
    logic [3:0][24:0] prod;
    logic [31:0]      color;
    logic [2:0][15:0] rem;
    logic [2:0][7:0]  quo;
    logic [9:0]       den;
    logic             big;
  } pipe_t;

  // Two quotient bits of a restoring division; hi is the upper bit position
  function automatic logic [17:0] div_step2(input logic [15:0] rem, input logic [9:0] den,
                                            input logic [2:0] hi);
    logic [16:0] r;
    logic [16:0] d_hi;
    logic [16:0] d_lo;
    logic [1:0]  q;
    r    = {1'b0, rem};
    d_hi = 17'(den) << hi;
    d_lo = 17'(den) << (hi - 3'd1);
    q[1] = (r >= d_hi);
    if (q[1]) begin
      r = r - d_hi;
    end
    q[0] = (r >= d_lo);
    if (q[0]) begin
      r = r - d_lo;
    end
    return {q, r[15:0]};
  endfunction

  function automatic logic [7:0] sat8(input logic signed [10:0] v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  // Lower and upper of the two layers not painted
  function automatic logic [1:0] other_lo(input logic [1:0] p);
    return (p == 2'd0) ? 2'd1 : 2'd0;
  endfunction

  function automatic logic [1:0] other_hi(input logic [1:0] p);
    return (p == 2'd2) ? 2'd1 : 2'd2;
  endfunction

  logic [vswp_pkg::W_MODE-1:0] mode_r;
  pipe_t                       pipe_r   [NS];
  pipe_t                       pipe_nxt [NS];
  logic [NS-1:0]               valid_r;
  logic [NS-1:0]               valid_nxt;
  logic [NS-1:0]               en;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= vswp_pkg::MODE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == vswp_pkg::ADDR_PAINT_MODE) begin
      mode_r <= cfg_pwdata[vswp_pkg::W_MODE-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == vswp_pkg::ADDR_PAINT_MODE) ?
                      vswp_pkg::W_CFG_DATA'(mode_r) : '0;

  // Stage enables: a stage moves when it is empty or the next one moves
  always_comb begin
    en[NS-1] = !valid_r[NS-1] || out_ch.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
  end

  assign in_ch.ready = en[ST_IN];

  always_comb begin
    valid_nxt[ST_IN] = in_ch.valid;
    for (int k = 1; k < NS; k++) begin
      valid_nxt[k] = valid_r[k-1];
    end
  end

  // Stage datapath
  always_comb begin
    logic signed [15:0] infl;
    logic signed [15:0] clamp;
    logic signed [23:0] c24;
    logic signed [23:0] scaled;
    logic signed [8:0]  dt;
    logic signed [25:0] blend;
    logic [31:0]        mixed;
    logic [1:0]         p;
    logic [1:0]         s_lo;
    logic [1:0]         s_hi;
    logic [7:0]         o_lo;
    logic [7:0]         o_hi;
    logic [7:0]         mag;
    logic [7:0]         o;
    logic [9:0]         sum;
    logic [17:0]        dres;
    logic signed [10:0] v;

    v = '0;
    o = '0;

    // Input stage: clamp influence, weight step, per-channel colour products
    infl  = in_ch.brush_influence;
    clamp = infl;
    if (infl > ONE_S) begin
      clamp = ONE_S;
    end else if (infl < -ONE_S) begin
      clamp = -ONE_S;
    end
    c24    = 24'(clamp);
    scaled = (c24 <<< 8) - c24;
    pipe_nxt[ST_IN]        = '0;
    pipe_nxt[ST_IN].w      = {in_ch.weight_two, in_ch.weight_one, in_ch.weight_zero};
    pipe_nxt[ST_IN].idx    = {in_ch.tex_index_two, in_ch.tex_index_one,
                              in_ch.tex_index_zero};
    pipe_nxt[ST_IN].tid    = in_ch.stamp_id;
    pipe_nxt[ST_IN].layer  = in_ch.paint_layer;
    pipe_nxt[ST_IN].step   = 10'(scaled >>> INFLUENCE_FRAC_BITS);
    pipe_nxt[ST_IN].tex    = (mode_r != vswp_pkg::MODE_DIFF) &&
                             (in_ch.paint_layer < 2'(vswp_pkg::NUM_LAYERS)) &&
                             (pipe_nxt[ST_IN].step != 10'd0);
    pipe_nxt[ST_IN].color  = in_ch.cur_color;
    for (int k = 0; k < 4; k++) begin
      dt = $signed({1'b0, in_ch.target_color[8*k +: 8]}) -
           $signed({1'b0, in_ch.cur_color[8*k +: 8]});
      pipe_nxt[ST_IN].prod[k] = 25'(25'(dt) * 25'(infl));
    end

    // Painted layer, share numerators, colour blend
    pipe_nxt[ST_PRE] = pipe_r[ST_IN];
    p    = pipe_r[ST_IN].layer;
    s_lo = other_lo(p);
    s_hi = other_hi(p);
    o_lo = pipe_r[ST_IN].w[s_lo];
    o_hi = pipe_r[ST_IN].w[s_hi];
    mag  = pipe_r[ST_IN].step[9] ? 8'(-pipe_r[ST_IN].step) : pipe_r[ST_IN].step[7:0];
    if (pipe_r[ST_IN].tex) begin
      pipe_nxt[ST_PRE].idx[p] = pipe_r[ST_IN].tid;
      v = $signed({3'b0, pipe_r[ST_IN].w[p]}) + 11'($signed(pipe_r[ST_IN].step));
      pipe_nxt[ST_PRE].w[p] = sat8(v);
    end
    pipe_nxt[ST_PRE].den    = {2'b0, o_lo} + {2'b0, o_hi};
    pipe_nxt[ST_PRE].rem[0] = o_lo * mag;
    pipe_nxt[ST_PRE].rem[1] = o_hi * mag;
    pipe_nxt[ST_PRE].rem[2] = '0;
    for (int k = 0; k < 4; k++) begin
      blend = $signed({18'b0, pipe_r[ST_IN].color[8*k +: 8]}) +
              26'($signed(pipe_r[ST_IN].prod[k]) >>> INFLUENCE_FRAC_BITS);
      if (blend < 0) begin
        mixed[8*k +: 8] = 8'd0;
      end else if (blend > 26'sd255) begin
        mixed[8*k +: 8] = 8'd255;
      end else begin
        mixed[8*k +: 8] = blend[7:0];
      end
    end
    if (mode_r != vswp_pkg::MODE_TEX) begin
      pipe_nxt[ST_PRE].color = mixed;
    end

    // Share division, two quotient bits a stage
    for (int j = 0; j < DIV_ST; j++) begin
      pipe_nxt[ST_SD0+j] = pipe_r[ST_SD0+j-1];
      for (int i = 0; i < 3; i++) begin
        dres = div_step2(pipe_r[ST_SD0+j-1].rem[i], pipe_r[ST_SD0+j-1].den, 3'(7 - 2*j));
        pipe_nxt[ST_SD0+j].rem[i] = dres[15:0];
        pipe_nxt[ST_SD0+j].quo[i] = {pipe_r[ST_SD0+j-1].quo[i][5:0], dres[17:16]};
      end
    end

    // Apply shares to the other layers, then set up the rescale
    pipe_nxt[ST_MID] = pipe_r[ST_MID-1];
    if (pipe_r[ST_MID-1].tex) begin
      for (int i = 0; i < 2; i++) begin
        s_lo = (i == 0) ? other_lo(pipe_r[ST_MID-1].layer) : other_hi(pipe_r[ST_MID-1].layer);
        o    = pipe_r[ST_MID-1].w[s_lo];
        if (pipe_r[ST_MID-1].step[9]) begin
          v = $signed({3'b0, o}) + $signed({3'b0, pipe_r[ST_MID-1].quo[i]});
        end else begin
          v = $signed({3'b0, o}) - $signed({3'b0, pipe_r[ST_MID-1].quo[i]});
        end
        if (o != 8'd0) begin
          pipe_nxt[ST_MID].w[s_lo] = sat8(v);
        end
      end
    end
    sum = {2'b0, pipe_nxt[ST_MID].w[0]} + {2'b0, pipe_nxt[ST_MID].w[1]} +
          {2'b0, pipe_nxt[ST_MID].w[2]};
    pipe_nxt[ST_MID].den = sum;
    pipe_nxt[ST_MID].big = (sum > 10'd255);
    for (int i = 0; i < 3; i++) begin
      pipe_nxt[ST_MID].rem[i] = {pipe_nxt[ST_MID].w[i], 8'd0} -
                                {8'd0, pipe_nxt[ST_MID].w[i]};
    end

    // Rescale division
    for (int j = 0; j < DIV_ST; j++) begin
      pipe_nxt[ST_RD0+j] = pipe_r[ST_RD0+j-1];
      for (int i = 0; i < 3; i++) begin
        dres = div_step2(pipe_r[ST_RD0+j-1].rem[i], pipe_r[ST_RD0+j-1].den, 3'(7 - 2*j));
        pipe_nxt[ST_RD0+j].rem[i] = dres[15:0];
        pipe_nxt[ST_RD0+j].quo[i] = {pipe_r[ST_RD0+j-1].quo[i][5:0], dres[17:16]};
      end
    end

    // Output stage: rescaled weights where the sum overflowed
    pipe_nxt[ST_OUT] = pipe_r[ST_OUT-1];
    if (pipe_r[ST_OUT-1].tex && pipe_r[ST_OUT-1].big) begin
      pipe_nxt[ST_OUT].w = pipe_r[ST_OUT-1].quo;
    end
  end

  // Pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          valid_r[k] <= valid_nxt[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        pipe_r[k] <= pipe_nxt[k];
      end
    end
  end

  // Result channel
  assign out_ch.valid            = valid_r[ST_OUT];
  assign out_ch.new_weight_zero  = pipe_r[ST_OUT].w[0];
  assign out_ch.new_weight_one   = pipe_r[ST_OUT].w[1];
  assign out_ch.new_weight_two   = pipe_r[ST_OUT].w[2];
  assign out_ch.new_index_zero   = pipe_r[ST_OUT].idx[0];
  assign out_ch.new_index_one    = pipe_r[ST_OUT].idx[1];
  assign out_ch.new_index_two    = pipe_r[ST_OUT].idx[2];
  assign out_ch.new_color        = pipe_r[ST_OUT].color;
  assign out_ch.weights_changed  = pipe_r[ST_OUT].tex;

`ifndef NO_ASSERTIONS
  // An empty output stage always lets the pipe take an item
  a_ready_when_out_empty: assert property (
    @(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready
  ) else $error("input stalled with empty output stage");

  // Painted weights never sum above 255
  a_weight_sum: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.weights_changed) |->
      (({2'b0, out_ch.new_weight_zero} + {2'b0, out_ch.new_weight_one} +
        {2'b0, out_ch.new_weight_two}) <= 10'd255)
  ) else $error("painted weights sum above 255");

  // A stalled result stays in place
  a_out_hold: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(pipe_r[ST_OUT]))
  ) else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the vertex splat weight painter: random vertices, stalls, modes.
`timescale 1ns / 1ps

localparam int INFL_FRAC = vswp_pkg::INFLUENCE_FRAC_BITS_DEF;
localparam int INFL_ONE  = 1 << INFL_FRAC;

// Paint mode three has no package name; it behaves like both
localparam logic [vswp_pkg::W_MODE-1:0] MODE_BOTH_ALT = 2'd3;

typedef struct packed {
  logic [vswp_pkg::W_BYTE-1:0]        weight_zero;
  logic [vswp_pkg::W_BYTE-1:0]        weight_one;
  logic [vswp_pkg::W_BYTE-1:0]        weight_two;
  logic [vswp_pkg::W_BYTE-1:0]        tex_index_zero;
  logic [vswp_pkg::W_BYTE-1:0]        tex_index_one;
  logic [vswp_pkg::W_BYTE-1:0]        tex_index_two;
  logic [vswp_pkg::W_COLOR-1:0]       cur_color;
  logic [vswp_pkg::W_COLOR-1:0]       target_color;
  logic signed [vswp_pkg::W_INFL-1:0] brush_influence;
  logic [vswp_pkg::W_LAYER-1:0]       paint_layer;
  logic [vswp_pkg::W_BYTE-1:0]        stamp_id;
} vertex_t;

typedef struct packed {
  logic [vswp_pkg::W_BYTE-1:0]  new_weight_zero;
  logic [vswp_pkg::W_BYTE-1:0]  new_weight_one;
  logic [vswp_pkg::W_BYTE-1:0]  new_weight_two;
  logic [vswp_pkg::W_BYTE-1:0]  new_index_zero;
  logic [vswp_pkg::W_BYTE-1:0]  new_index_one;
  logic [vswp_pkg::W_BYTE-1:0]  new_index_two;
  logic [vswp_pkg::W_COLOR-1:0] new_color;
  logic                         weights_changed;
} painted_t;

// Receiver ready patterns
typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_DENSE} rx_style_t;

// Predicts each painted vertex and matches it against what comes out
class splat_scoreboard;
  logic [vswp_pkg::W_MODE-1:0] paint_mode;
  painted_t                    painted_due[$];
  int                          errors;
  int                          results_seen;

  function new();
    paint_mode   = vswp_pkg::MODE_RESET;
    errors       = 0;
    results_seen = 0;
  endfunction

  task report(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  function int sat_byte(int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  // trunc(a * step / den), den > 0
  function int take_share(int a, int step, int den);
    int mag;
    int q;
    mag = (step < 0) ? -step : step;
    q = (a * mag) / den;
    return (step < 0) ? -q : q;
  endfunction

  function painted_t paint_vertex(vertex_t v);
    int w[3];
    int idx[3];
    int infl, c, step, p, s1, s2, o1, o2, sum, cc, tt, blend;
    painted_t r;
    w[0] = v.weight_zero;
    w[1] = v.weight_one;
    w[2] = v.weight_two;
    idx[0] = v.tex_index_zero;
    idx[1] = v.tex_index_one;
    idx[2] = v.tex_index_two;
    infl = $signed(v.brush_influence);
    r = '0;
    r.new_color = v.cur_color;

    // texture weights: clamp influence to one, turn it into a step of -255..255
    if (paint_mode != vswp_pkg::MODE_DIFF && v.paint_layer != 2'd3) begin
      c = infl;
      if (c > INFL_ONE) c = INFL_ONE;
      if (c < -INFL_ONE) c = -INFL_ONE;
      step = (c * 255) >>> INFL_FRAC;
      if (step != 0) begin
        p  = v.paint_layer;
        s1 = (p == 0) ? 1 : 0;
        s2 = (p == 2) ? 1 : 2;
        o1 = w[s1];
        o2 = w[s2];
        idx[p] = v.stamp_id;
        w[p] = sat_byte(w[p] + step);
        if (o1 != 0) w[s1] = sat_byte(o1 - take_share(o1, step, o1 + o2));
        if (o2 != 0) w[s2] = sat_byte(o2 - take_share(o2, step, o1 + o2));
        sum = w[0] + w[1] + w[2];
        if (sum > 255)
          for (int k = 0; k < 3; k++) w[k] = (w[k] * 255) / sum;
        r.weights_changed = 1'b1;
      end
    end

    // diffuse blend per channel, influence not clamped here
    if (paint_mode != vswp_pkg::MODE_TEX) begin
      for (int ch = 0; ch < 4; ch++) begin
        cc = v.cur_color[8*ch +: 8];
        tt = v.target_color[8*ch +: 8];
        blend = sat_byte(cc + (((tt - cc) * infl) >>> INFL_FRAC));
        r.new_color[8*ch +: 8] = blend[7:0];
      end
    end

    r.new_weight_zero = w[0][7:0];
    r.new_weight_one  = w[1][7:0];
    r.new_weight_two  = w[2][7:0];
    r.new_index_zero  = idx[0][7:0];
    r.new_index_one   = idx[1][7:0];
    r.new_index_two   = idx[2][7:0];
    return r;
  endfunction

  function void note_vertex(vertex_t v);
    painted_due.push_back(paint_vertex(v));
  endfunction

  function int pending();
    return painted_due.size();
  endfunction

  task check_result(painted_t got);
    painted_t exp;
    results_seen++;
    if (painted_due.size() == 0) begin
      report($sformatf("result %0d arrived with no vertex pending", results_seen));
    end else begin
      exp = painted_due.pop_front();
      if (got.new_weight_zero !== exp.new_weight_zero)
        report($sformatf("result %0d new_weight_zero got %0d exp %0d", results_seen,
                         got.new_weight_zero, exp.new_weight_zero));
      if (got.new_weight_one !== exp.new_weight_one)
        report($sformatf("result %0d new_weight_one got %0d exp %0d", results_seen,
                         got.new_weight_one, exp.new_weight_one));
      if (got.new_weight_two !== exp.new_weight_two)
        report($sformatf("result %0d new_weight_two got %0d exp %0d", results_seen,
                         got.new_weight_two, exp.new_weight_two));
      if (got.new_index_zero !== exp.new_index_zero)
        report($sformatf("result %0d new_index_zero got %0d exp %0d", results_seen,
                         got.new_index_zero, exp.new_index_zero));
      if (got.new_index_one !== exp.new_index_one)
        report($sformatf("result %0d new_index_one got %0d exp %0d", results_seen,
                         got.new_index_one, exp.new_index_one));
      if (got.new_index_two !== exp.new_index_two)
        report($sformatf("result %0d new_index_two got %0d exp %0d", results_seen,
                         got.new_index_two, exp.new_index_two));
      if (got.new_color !== exp.new_color)
        report($sformatf("result %0d new_color got %h exp %h", results_seen,
                         got.new_color, exp.new_color));
      if (got.weights_changed !== exp.weights_changed)
        report($sformatf("result %0d weights_changed got %b exp %b", results_seen,
                         got.weights_changed, exp.weights_changed));
    end
  endtask
endclass

module testbench;

  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE_ITEMS   = 170;

  logic clk = 1'b0;
  logic rst_n;

  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [vswp_pkg::W_CFG_ADDR-1:0] cfg_paddr;
  logic [vswp_pkg::W_CFG_DATA-1:0] cfg_pwdata;
  logic [vswp_pkg::W_CFG_DATA-1:0] cfg_prdata;
  logic                            cfg_pready;

  int holds_asked = 0;

  vswp_in_if  in_if();
  vswp_out_if out_if();

  splat_scoreboard sb = new();

  vertex_splat_weight_painter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  // Run limit
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: changing ready patterns, plus long hold-offs on request
  initial begin : receiver
    int holds_done;
    int hold_left;
    int seg_left;
    rx_style_t style;
    holds_done = 0;
    hold_left = 0;
    seg_left = 0;
    style = RX_OPEN;
    out_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(5, 60);
          style = rx_style_t'($urandom_range(0, 3));
        end
        seg_left--;
        case (style)
          RX_OPEN:   out_if.ready <= 1'b1;
          RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
          default:   out_if.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Grab accepted results
  always @(posedge clk) begin : grab_result
    painted_t got;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.new_weight_zero  = out_if.new_weight_zero;
      got.new_weight_one   = out_if.new_weight_one;
      got.new_weight_two   = out_if.new_weight_two;
      got.new_index_zero   = out_if.new_index_zero;
      got.new_index_one    = out_if.new_index_one;
      got.new_index_two    = out_if.new_index_two;
      got.new_color        = out_if.new_color;
      got.weights_changed  = out_if.weights_changed;
      sb.check_result(got);
    end
  end

  // Offer one vertex from a falling edge; return at the falling edge after it is taken
  task send_vertex(input vertex_t v);
    in_if.weight_zero     = v.weight_zero;
    in_if.weight_one      = v.weight_one;
    in_if.weight_two      = v.weight_two;
    in_if.tex_index_zero  = v.tex_index_zero;
    in_if.tex_index_one   = v.tex_index_one;
    in_if.tex_index_two   = v.tex_index_two;
    in_if.cur_color       = v.cur_color;
    in_if.target_color    = v.target_color;
    in_if.brush_influence = v.brush_influence;
    in_if.paint_layer     = v.paint_layer;
    in_if.stamp_id        = v.stamp_id;
    in_if.valid           = 1'b1;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    sb.note_vertex(v);
    @(negedge clk);
  endtask

  task idle_input(input int cycles);
    if (cycles > 0) begin
      in_if.valid = 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  task cfg_write(input logic [vswp_pkg::W_CFG_ADDR-1:0] addr,
                 input logic [vswp_pkg::W_CFG_DATA-1:0] data);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = addr;
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task cfg_read(input logic [vswp_pkg::W_CFG_ADDR-1:0] addr,
                output logic [vswp_pkg::W_CFG_DATA-1:0] data);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = addr;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    data = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // Write the mode, mirror it and read it back
  task set_paint_mode(input logic [vswp_pkg::W_MODE-1:0] mode);
    logic [vswp_pkg::W_CFG_DATA-1:0] rd;
    cfg_write(vswp_pkg::ADDR_PAINT_MODE,
              {{(vswp_pkg::W_CFG_DATA-vswp_pkg::W_MODE){1'b0}}, mode});
    sb.paint_mode = mode;
    cfg_read(vswp_pkg::ADDR_PAINT_MODE, rd);
    if (rd !== {{(vswp_pkg::W_CFG_DATA-vswp_pkg::W_MODE){1'b0}}, mode})
      sb.report($sformatf("paint_mode read %h exp %0d", rd, mode));
  endtask

  // Wait until every pending vertex has come back, then let the pipe settle
  task wait_for_painted();
    int guard;
    in_if.valid = 1'b0;
    guard = 0;
    while (sb.pending() > 0 && guard < 50000) begin
      @(negedge clk);
      guard++;
    end
    if (sb.pending() > 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function vertex_t mk_vertex(input logic [7:0] w0, input logic [7:0] w1,
                              input logic [7:0] w2, input logic [1:0] layer,
                              input int infl, input logic [31:0] col,
                              input logic [31:0] tgt, input logic [7:0] tid);
    vertex_t v;
    v.weight_zero     = w0;
    v.weight_one      = w1;
    v.weight_two      = w2;
    v.tex_index_zero  = 8'($urandom_range(0, 255));
    v.tex_index_one   = 8'($urandom_range(0, 255));
    v.tex_index_two   = 8'($urandom_range(0, 255));
    v.cur_color       = col;
    v.target_color    = tgt;
    v.brush_influence = infl[15:0];
    v.paint_layer     = layer;
    v.stamp_id        = tid;
    return v;
  endfunction

  // Weights lean toward the edges: empty, full and nearly empty layers
  function logic [7:0] random_weight();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(1, 16));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function vertex_t random_vertex();
    vertex_t v;
    int infl;
    logic [31:0] col;
    logic [31:0] tgt;
    case ($urandom_range(0, 9))
      0:       infl = $urandom_range(0, 1) ? INFL_ONE : -INFL_ONE;
      1:       infl = $signed(16'($urandom));
      2:       infl = $urandom_range(0, 40) - 20;
      3:       infl = $urandom_range(0, 1) ? 32767 : -32768;
      default: infl = $urandom_range(0, 2 * INFL_ONE) - INFL_ONE;
    endcase
    col = $urandom;
    case ($urandom_range(0, 5))
      0:       tgt = col;
      1:       tgt = 32'h0000_0000;
      2:       tgt = 32'hffff_ffff;
      default: tgt = $urandom;
    endcase
    v = mk_vertex(random_weight(), random_weight(), random_weight(),
                  ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                  infl, col, tgt, 8'($urandom_range(0, 255)));
    return v;
  endfunction

  initial begin : stimulus
    logic [vswp_pkg::W_CFG_DATA-1:0] rd;
    logic [vswp_pkg::W_MODE-1:0] mode_plan [6];
    int sent;
    int burst;
    mode_plan = '{vswp_pkg::MODE_TEX, vswp_pkg::MODE_DIFF, MODE_BOTH_ALT,
                  vswp_pkg::MODE_BOTH, vswp_pkg::MODE_TEX, vswp_pkg::MODE_DIFF};

    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_if.valid = 1'b0;
    in_if.weight_zero = '0;
    in_if.weight_one = '0;
    in_if.weight_two = '0;
    in_if.tex_index_zero = '0;
    in_if.tex_index_one = '0;
    in_if.tex_index_two = '0;
    in_if.cur_color = '0;
    in_if.target_color = '0;
    in_if.brush_influence = '0;
    in_if.paint_layer = '0;
    in_if.stamp_id = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset value of the mode register
    cfg_read(vswp_pkg::ADDR_PAINT_MODE, rd);
    if (rd !== {{(vswp_pkg::W_CFG_DATA-vswp_pkg::W_MODE){1'b0}}, vswp_pkg::MODE_RESET})
      sb.report($sformatf("paint_mode after reset read %h", rd));

    // directed corners under the reset mode (both)
    send_vertex(mk_vertex(8'd0, 8'd0, 8'd0, 2'd0, 0, 32'h0, 32'h0, 8'h00));
    send_vertex(mk_vertex(8'd100, 8'd100, 8'd55, 2'd0, INFL_ONE,
                          32'h0000_0000, 32'hffff_ffff, 8'hff));
    send_vertex(mk_vertex(8'd60, 8'd120, 8'd75, 2'd1, -INFL_ONE,
                          32'hffff_ffff, 32'h0000_0000, 8'h00));
    send_vertex(mk_vertex(8'd255, 8'd255, 8'd255, 2'd2, 32767,
                          32'h8080_8080, 32'hff00_ff00, 8'ha5));
    send_vertex(mk_vertex(8'd255, 8'd255, 8'd255, 2'd0, -32768,
                          32'h1234_5678, 32'hfedc_ba98, 8'h5a));
    // smallest influences: +1 rounds to no step, -1 floors to a step of -1
    send_vertex(mk_vertex(8'd10, 8'd20, 8'd30, 2'd1, 1,
                          32'h00ff_00ff, 32'hff00_ff00, 8'h11));
    send_vertex(mk_vertex(8'd10, 8'd20, 8'd30, 2'd2, -1,
                          32'h00ff_00ff, 32'hff00_ff00, 8'h22));
    // layer three leaves the weights alone
    send_vertex(mk_vertex(8'd200, 8'd40, 8'd15, 2'd3, INFL_ONE,
                          32'h4040_4040, 32'hc0c0_c0c0, 8'h33));
    // other two layers empty
    send_vertex(mk_vertex(8'd0, 8'd77, 8'd0, 2'd1, -2048,
                          32'hffff_ffff, 32'h0000_0000, 8'h44));
    // one other layer empty, erasing pushes the rest up
    send_vertex(mk_vertex(8'd255, 8'd0, 8'd200, 2'd0, -INFL_ONE,
                          32'h0000_0000, 32'h0000_0000, 8'h55));
    send_vertex(mk_vertex(8'd0, 8'd0, 8'd0, 2'd2, INFL_ONE,
                          32'hffff_ffff, 32'hffff_ffff, 8'h66));
    send_vertex(mk_vertex(8'd1, 8'd1, 8'd1, 2'd0, 17,
                          32'h0102_0304, 32'hfefd_fcfb, 8'h77));
    send_vertex(mk_vertex(8'd3, 8'd250, 8'd2, 2'd1, -17,
                          32'hfefd_fcfb, 32'h0102_0304, 8'h88));
    send_vertex(mk_vertex(8'd255, 8'd0, 8'd0, 2'd0, INFL_ONE,
                          32'h7f7f_7f7f, 32'h8080_8080, 8'h99));
    send_vertex(mk_vertex(8'd0, 8'd255, 8'd255, 2'd0, INFL_ONE - 1,
                          32'h00ff_00ff, 32'hffff_0000, 8'haa));
    send_vertex(mk_vertex(8'd128, 8'd64, 8'd32, 2'd2, 2 * INFL_ONE,
                          32'h2040_6080, 32'hffff_ffff, 8'hbb));
    wait_for_painted();

    // random phases, one per mode setting
    for (int ph = 0; ph < 6; ph++) begin
      set_paint_mode(mode_plan[ph]);
      if (ph == 2) begin
        // receiver holds off while the sender keeps pushing: the pipe fills and stalls
        holds_asked++;
        repeat (80) send_vertex(random_vertex());
        idle_input(1);
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 24);
        for (int b = 0; b < burst; b++) send_vertex(random_vertex());
        sent += burst;
        idle_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      end
      wait_for_painted();
    end

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/vswp_pkg.sv
rtl/vswp_in_if.sv
rtl/vswp_out_if.sv
rtl/vertex_splat_weight_painter.sv
test/testbench.sv
